// ===== sv/gbf_pkg.sv =====
// Shared constants for the graph bridge finder.
package gbf_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 128;
    localparam int MAX_RESULTS   = 64;
    localparam int NODE_W        = 6;
    localparam int RES_CNT_W     = 7;

    localparam logic [NODE_W-1:0] ROOT_RESET = 6'd1;

    // Register map (byte addresses)
    localparam logic [0:0] REG_ROOT = 1'b0;

    // Controller states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LA    = 4'd1;
    localparam logic [3:0] ST_LB    = 4'd2;
    localparam logic [3:0] ST_START = 4'd3;
    localparam logic [3:0] ST_ROOT  = 4'd4;
    localparam logic [3:0] ST_EDGE  = 4'd5;
    localparam logic [3:0] ST_TGT   = 4'd6;
    localparam logic [3:0] ST_BACK  = 4'd7;
    localparam logic [3:0] ST_PUSH  = 4'd8;
    localparam logic [3:0] ST_POP   = 4'd9;
    localparam logic [3:0] ST_POPD  = 4'd10;
    localparam logic [3:0] ST_END   = 4'd11;

endpackage

// ===== sv/gbf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module gbf_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/graph_bridge_finder_unit.sv =====
// Bridge finder: edges stream in (each as two adjacency appends through the node RAM
// read-modify-write); after the edge marked tlast a depth-first walk runs from
// root_node with a frame stack in RAM. Each adjacency entry of the root's component is
// read and skipped if it leads back to the tree parent, else used for a back-edge
// update or a push; a tree node, the root included, is popped when its entries run
// out. A stalled result output holds the walk. Bridges come out as (parent, child)
// in the order children finish; the last of a run has tlast set. A run without bridges
// gives one result with found clear. All graph state is cleared when the last result is
// loaded into the output register; root_node keeps its value.
module graph_bridge_finder_unit #(
    parameter int MAX_NODES = gbf_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = gbf_pkg::MAX_EDGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // end_a[5:0], end_b[11:6], zero[15:12]
    input  logic        s_tlast,   // last_edge
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // bridge_parent[5:0], bridge_child[11:6], zero[15:12]
    output logic [1:0]  m_tuser,   // found[0], edges_dropped[1]
    output logic        m_tlast,   // last_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int ECAP = 2 * MAX_EDGES;
    localparam int EW   = $clog2(ECAP);
    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = EW + 1;
    localparam int DW   = NW + 1;
    localparam int FW   = 4 * NW + 2 * EW + 2;
    localparam int IW   = gbf_pkg::NODE_W;

    logic [3:0]    state_reg;
    logic [IW-1:0] root_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic [MAX_NODES-1:0] nonempty_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [NW-1:0] a_reg, b_reg;
    logic          last_reg;
    logic [EW-1:0] fwd_head_reg, fwd_tail_reg;
    logic [DW-1:0] clock_reg, depth_reg;
    logic [NW-1:0] c_reg;
    logic [gbf_pkg::RES_CNT_W-1:0] res_cnt_reg;
    logic          pend_valid_reg;
    logic [NW-1:0] pend_par_reg, pend_chi_reg;

    // top frame
    logic [NW-1:0] fr_node_reg, fr_par_reg, fr_disc_reg, fr_low_reg;
    logic          fr_hp_reg, fr_cv_reg;
    logic [EW-1:0] fr_cur_reg, fr_tail_reg;

    logic          m_valid_reg, m_found_reg, m_drop_reg, m_last_reg;
    logic [NW-1:0] m_par_reg, m_chi_reg;

    // RAM ports
    logic          tgt_we, tgt_re, link_we, link_re, node_we, node_re;
    logic          disc_we, disc_re, stk_we, stk_re;
    logic [EW-1:0] tgt_waddr, link_waddr, link_wdata, adj_raddr;
    logic [NW-1:0] tgt_wdata, tgt_rdata, disc_wdata, disc_rdata;
    logic [EW-1:0] link_rdata;
    logic [NW-1:0] node_waddr, node_raddr, disc_waddr, disc_raddr, stk_waddr, stk_raddr;
    logic [2*EW-1:0] node_wdata, node_rdata;
    logic [FW-1:0] stk_wdata, stk_rdata;

    logic [IW-1:0] in_a, in_b;
    logic          in_bad, s_acc, slot_free;
    logic [EW-1:0] ent_a, rd_head, rd_tail, lb_head, lb_tail;
    logic          lb_ne;
    logic [EW-1:0] nxt_cur;
    logic          nxt_cv;
    logic          c_is_par;
    logic [NW-1:0] p_node, p_par, p_disc, p_low;
    logic          p_hp, p_cv;
    logic [EW-1:0] p_cur, p_tail;
    logic          is_bridge, need_out;
    logic          out_load;

    assign in_a   = s_tdata[IW-1:0];
    assign in_b   = s_tdata[2*IW-1:IW];
    assign in_bad = (32'(in_a) >= 32'(MAX_NODES)) || (32'(in_b) >= 32'(MAX_NODES))
                    || (32'(cnt_reg) + 32'd2 > 32'(ECAP));
    assign s_tready = (state_reg == gbf_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    assign ent_a = cnt_reg[EW-1:0];
    assign rd_head = node_rdata[2*EW-1:EW];
    assign rd_tail = node_rdata[EW-1:0];
    assign lb_ne   = (a_reg == b_reg) ? 1'b1 : nonempty_reg[b_reg];
    assign lb_head = (a_reg == b_reg) ? fwd_head_reg : rd_head;
    assign lb_tail = (a_reg == b_reg) ? fwd_tail_reg : rd_tail;

    assign nxt_cur  = link_rdata;
    assign nxt_cv   = (fr_cur_reg != fr_tail_reg);
    assign c_is_par = fr_hp_reg && (tgt_rdata == fr_par_reg);

    assign {p_node, p_par, p_hp, p_cur, p_cv, p_tail, p_disc, p_low} = stk_rdata;
    assign is_bridge = (fr_low_reg > p_disc) && (32'(res_cnt_reg) < gbf_pkg::MAX_RESULTS);
    assign need_out  = is_bridge && pend_valid_reg;
    assign out_load  = ((state_reg == gbf_pkg::ST_POPD) && need_out && slot_free)
                       || ((state_reg == gbf_pkg::ST_END) && slot_free);

    always_comb begin
        tgt_we = 1'b0; tgt_waddr = ent_a; tgt_wdata = b_reg;
        link_we = 1'b0; link_waddr = rd_tail; link_wdata = ent_a;
        node_we = 1'b0; node_waddr = a_reg; node_wdata = '0;
        node_re = 1'b0; node_raddr = NW'(in_a);
        tgt_re = 1'b0; link_re = 1'b0; adj_raddr = fr_cur_reg;
        disc_we = 1'b0; disc_waddr = fr_node_reg; disc_wdata = NW'(clock_reg);
        disc_re = 1'b0; disc_raddr = tgt_rdata;
        stk_we = 1'b0; stk_waddr = NW'(depth_reg - DW'(1));
        stk_wdata = {fr_node_reg, fr_par_reg, fr_hp_reg, nxt_cur, nxt_cv, fr_tail_reg,
                     fr_disc_reg, fr_low_reg};
        stk_re = 1'b0; stk_raddr = NW'(depth_reg - DW'(2));
        case (state_reg)
            gbf_pkg::ST_IDLE: begin
                node_re = s_acc && !in_bad;
            end
            gbf_pkg::ST_LA: begin
                tgt_we = 1'b1;
                link_we = nonempty_reg[a_reg];
                node_we = 1'b1;
                node_wdata = {nonempty_reg[a_reg] ? rd_head : ent_a, ent_a};
                node_re = 1'b1;
                node_raddr = b_reg;
            end
            gbf_pkg::ST_LB: begin
                tgt_we = 1'b1; tgt_waddr = ent_a; tgt_wdata = a_reg;
                link_we = lb_ne; link_waddr = lb_tail; link_wdata = ent_a;
                node_we = 1'b1; node_waddr = b_reg;
                node_wdata = {lb_ne ? lb_head : ent_a, ent_a};
            end
            gbf_pkg::ST_START: begin
                node_re = 1'b1; node_raddr = NW'(root_reg);
            end
            gbf_pkg::ST_ROOT, gbf_pkg::ST_PUSH: begin
                disc_we = 1'b1;
                disc_waddr = (state_reg == gbf_pkg::ST_ROOT) ? NW'(root_reg) : c_reg;
            end
            gbf_pkg::ST_EDGE: begin
                tgt_re = fr_cv_reg; link_re = fr_cv_reg;
            end
            gbf_pkg::ST_TGT: begin
                disc_re = visited_reg[tgt_rdata];
                stk_we = !c_is_par && !visited_reg[tgt_rdata]
                         && (32'(depth_reg) < 32'(MAX_NODES));
                node_re = stk_we; node_raddr = tgt_rdata;
            end
            gbf_pkg::ST_POP: begin
                stk_re = (depth_reg > DW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbf_pkg::ST_IDLE;
            root_reg <= gbf_pkg::ROOT_RESET;
            cnt_reg <= '0; ovf_reg <= 1'b0;
            nonempty_reg <= '0; visited_reg <= '0;
            clock_reg <= '0; depth_reg <= '0; res_cnt_reg <= '0;
            pend_valid_reg <= 1'b0; m_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == gbf_pkg::REG_ROOT) begin
                root_reg <= pwdata[IW-1:0];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                gbf_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        a_reg <= NW'(in_a); b_reg <= NW'(in_b); last_reg <= s_tlast;
                        if (in_bad) begin
                            ovf_reg <= 1'b1;
                            state_reg <= s_tlast ? gbf_pkg::ST_START : gbf_pkg::ST_IDLE;
                        end else begin
                            state_reg <= gbf_pkg::ST_LA;
                        end
                    end
                end
                gbf_pkg::ST_LA: begin
                    fwd_head_reg <= nonempty_reg[a_reg] ? rd_head : ent_a;
                    fwd_tail_reg <= ent_a;
                    nonempty_reg[a_reg] <= 1'b1;
                    cnt_reg <= cnt_reg + CW'(1);
                    state_reg <= gbf_pkg::ST_LB;
                end
                gbf_pkg::ST_LB: begin
                    nonempty_reg[b_reg] <= 1'b1;
                    cnt_reg <= cnt_reg + CW'(1);
                    state_reg <= last_reg ? gbf_pkg::ST_START : gbf_pkg::ST_IDLE;
                end
                gbf_pkg::ST_START: begin
                    state_reg <= (32'(root_reg) < 32'(MAX_NODES)) ? gbf_pkg::ST_ROOT
                                                                  : gbf_pkg::ST_END;
                end
                gbf_pkg::ST_ROOT: begin
                    fr_node_reg <= NW'(root_reg); fr_par_reg <= '0; fr_hp_reg <= 1'b0;
                    fr_cur_reg <= rd_head; fr_tail_reg <= rd_tail;
                    fr_cv_reg <= nonempty_reg[NW'(root_reg)];
                    fr_disc_reg <= NW'(clock_reg); fr_low_reg <= NW'(clock_reg);
                    visited_reg[NW'(root_reg)] <= 1'b1;
                    clock_reg <= clock_reg + DW'(1);
                    depth_reg <= DW'(1);
                    state_reg <= gbf_pkg::ST_EDGE;
                end
                gbf_pkg::ST_EDGE: begin
                    state_reg <= fr_cv_reg ? gbf_pkg::ST_TGT : gbf_pkg::ST_POP;
                end
                gbf_pkg::ST_TGT: begin
                    fr_cur_reg <= nxt_cur; fr_cv_reg <= nxt_cv;
                    c_reg <= tgt_rdata;
                    if (c_is_par) begin
                        state_reg <= gbf_pkg::ST_EDGE;
                    end else if (visited_reg[tgt_rdata]) begin
                        state_reg <= gbf_pkg::ST_BACK;
                    end else if (stk_we) begin
                        state_reg <= gbf_pkg::ST_PUSH;
                    end else begin
                        state_reg <= gbf_pkg::ST_EDGE;
                    end
                end
                gbf_pkg::ST_BACK: begin
                    if (disc_rdata < fr_low_reg) begin
                        fr_low_reg <= disc_rdata;
                    end
                    state_reg <= gbf_pkg::ST_EDGE;
                end
                gbf_pkg::ST_PUSH: begin
                    fr_par_reg <= fr_node_reg; fr_node_reg <= c_reg; fr_hp_reg <= 1'b1;
                    fr_cur_reg <= rd_head; fr_tail_reg <= rd_tail;
                    fr_cv_reg <= nonempty_reg[c_reg];
                    fr_disc_reg <= NW'(clock_reg); fr_low_reg <= NW'(clock_reg);
                    visited_reg[c_reg] <= 1'b1;
                    clock_reg <= clock_reg + DW'(1);
                    depth_reg <= depth_reg + DW'(1);
                    state_reg <= gbf_pkg::ST_EDGE;
                end
                gbf_pkg::ST_POP: begin
                    state_reg <= (depth_reg > DW'(1)) ? gbf_pkg::ST_POPD : gbf_pkg::ST_END;
                end
                gbf_pkg::ST_POPD: begin
                    if (!need_out || slot_free) begin
                        if (need_out) begin
                            m_found_reg <= 1'b1; m_last_reg <= 1'b0;
                            m_drop_reg <= ovf_reg;
                            m_par_reg <= pend_par_reg; m_chi_reg <= pend_chi_reg;
                        end
                        if (is_bridge) begin
                            pend_valid_reg <= 1'b1;
                            pend_par_reg <= p_node; pend_chi_reg <= fr_node_reg;
                            res_cnt_reg <= res_cnt_reg + gbf_pkg::RES_CNT_W'(1);
                        end
                        fr_node_reg <= p_node; fr_par_reg <= p_par; fr_hp_reg <= p_hp;
                        fr_cur_reg <= p_cur; fr_cv_reg <= p_cv; fr_tail_reg <= p_tail;
                        fr_disc_reg <= p_disc;
                        fr_low_reg <= (fr_low_reg < p_low) ? fr_low_reg : p_low;
                        depth_reg <= depth_reg - DW'(1);
                        state_reg <= gbf_pkg::ST_EDGE;
                    end
                end
                gbf_pkg::ST_END: begin
                    if (slot_free) begin
                        m_found_reg <= pend_valid_reg;
                        m_last_reg <= 1'b1; m_drop_reg <= ovf_reg;
                        m_par_reg <= pend_valid_reg ? pend_par_reg : '0;
                        m_chi_reg <= pend_valid_reg ? pend_chi_reg : '0;
                        // clear the graph for the next run
                        cnt_reg <= '0; ovf_reg <= 1'b0;
                        nonempty_reg <= '0; visited_reg <= '0;
                        clock_reg <= '0; depth_reg <= '0; res_cnt_reg <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg <= gbf_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= gbf_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, IW'(m_chi_reg), IW'(m_par_reg)};
    assign m_tuser  = {m_drop_reg, m_found_reg};
    assign m_tlast  = m_last_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == gbf_pkg::REG_ROOT) ? {26'b0, root_reg} : 32'b0;

    gbf_ram #(.W(NW), .D(ECAP)) u_tgt_ram (
        .aclk(aclk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
        .re(tgt_re), .raddr(adj_raddr), .rdata(tgt_rdata));

    gbf_ram #(.W(EW), .D(ECAP)) u_link_ram (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .re(link_re), .raddr(adj_raddr), .rdata(link_rdata));

    gbf_ram #(.W(2*EW), .D(MAX_NODES)) u_node_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(node_rdata));

    gbf_ram #(.W(NW), .D(MAX_NODES)) u_disc_ram (
        .aclk(aclk), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
        .re(disc_re), .raddr(disc_raddr), .rdata(disc_rdata));

    gbf_ram #(.W(FW), .D(MAX_NODES)) u_stack_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata));

endmodule
